// File: hdl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants for the integer-to-ASCII formatter
// Holds the command and result structs, the controller states and the
// character and request codes.
// ----------------------------------------------------------------------------
package i2a_pkg;

	localparam int MagW      = 32;
	localparam int DecDigits = 10;
	localparam int HexDigits = 8;
	localparam int BcdW      = 4 * DecDigits;

	localparam logic [1:0] REQ_DEC = 2'd0;

	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_UPPER = 8'h41;
	localparam logic [7:0] CHR_LOWER = 8'h61;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] value;
		logic        zero_pad;
		logic [3:0]  field_width;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_PAD,
		ST_SIGN,
		ST_DIGIT
	} state_t;

endpackage

// File: hdl/i2a_dabble.sv
// ----------------------------------------------------------------------------
// i2a_dabble: bit-serial binary to BCD converter
// Shifts the magnitude in one bit per cycle, adjusting each BCD digit by
// three when it is five or more, and pulses done when all ten digits are ready.
// ----------------------------------------------------------------------------
module i2a_dabble
	import i2a_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [MagW-1:0]  mag,
	output logic             done,
	output logic [BcdW-1:0]  bcd
);

	localparam int CntW = $clog2(MagW);

	logic [MagW-1:0] mag_q;
	logic [BcdW-1:0] bcd_q;
	logic [BcdW-1:0] adj;
	logic [CntW-1:0] cnt_q;
	logic            active_q;
	logic            done_q;

	// Each digit is adjusted on its own before the shift.
	always_comb begin
		for (int i = 0; i < DecDigits; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(MagW - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= mag;
			bcd_q <= '0;
		end else if (active_q) begin
			mag_q <= {mag_q[MagW-2:0], 1'b0};
			bcd_q <= {adj[BcdW-2:0], mag_q[MagW-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// File: hdl/integer_to_ascii_field_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_field_formatter_core: printf-style integer field formatter
// Formats one 32-bit value as signed decimal or hex text with padding and
// emits it one ASCII character per cycle.
// ----------------------------------------------------------------------------
// Usage: drive a command onto cmd and raise start. The transaction is taken
// at a rising edge where start is high and busy is low; busy stays high
// until the last character of that field has been registered.
// Each character is qualified by strobe, which is high for exactly one cycle
// per character, and result.last_char marks the final character of the field. The
// receiver cannot stall, so every strobed character must be taken as it
// appears.
// Sequence: decimal requests run a bit-serial binary to BCD conversion,
// then strip leading zero digits one per cycle (up to nine), then emit one
// character per cycle. A hex field skips the conversion and strips up to
// seven zero digits. The output holds any pad and sign characters ahead
// of the digits. A new command may be accepted in the cycle in which the
// last character is on the outputs.
// Reset clears the controller to idle and drops strobe; no partial field
// survives a reset.
// ----------------------------------------------------------------------------
module integer_to_ascii_field_formatter_core
	import i2a_pkg::*;
#(
	parameter int MAX_WIDTH = 9
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic strobe,
	output rsp_t result
);

	localparam logic [3:0] MaxW = 4'(MAX_WIDTH);

	state_t state_q, state_d;

	// Field attributes captured when the transaction is accepted.
	logic       upper_q, upper_d;
	logic       zpad_q, zpad_d;
	logic       neg_q, neg_d;
	logic [3:0] wsat_q, wsat_d;

	// Digit register, most significant digit in the top nibble.
	logic [BcdW-1:0] dig_q, dig_d;
	logic [3:0]      ndig_q, ndig_d;
	logic [3:0]      pad_q, pad_d;

	logic strobe_q, strobe_d;
	rsp_t res_q, res_d;

	// Decimal converter hookup.
	logic            dab_load;
	logic            dab_done;
	logic [BcdW-1:0] dab_bcd;
	logic [MagW-1:0] mag;

	logic [3:0] top_dig;
	logic [3:0] text_len;
	logic [3:0] pad_calc;
	logic [7:0] dig_char;
	logic [7:0] pad_char;
	logic       is_dec;
	logic       in_neg;

	assign is_dec = (cmd.req_type == REQ_DEC);
	assign in_neg = is_dec & cmd.value[MagW-1];
	// The most negative value negates to itself, which is correct when read
	// as an unsigned magnitude.
	assign mag    = in_neg ? (MagW'(0) - cmd.value) : cmd.value;

	i2a_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (dab_load),
		.mag    (mag),
		.done   (dab_done),
		.bcd    (dab_bcd)
	);

	assign top_dig  = dig_q[BcdW-1 -: 4];
	assign text_len = ndig_q + {3'b000, neg_q};
	assign pad_calc = (wsat_q > text_len) ? (wsat_q - text_len) : 4'd0;
	assign pad_char = zpad_q ? CHR_ZERO : CHR_SPACE;

	always_comb begin
		if (top_dig > 4'd9) begin
			dig_char = (upper_q ? CHR_UPPER : CHR_LOWER) + {4'b0000, top_dig} - 8'd10;
		end else begin
			dig_char = CHR_ZERO + {4'b0000, top_dig};
		end
	end

	always_comb begin
		state_d  = state_q;
		upper_d  = upper_q;
		zpad_d   = zpad_q;
		neg_d    = neg_q;
		wsat_d   = wsat_q;
		dig_d    = dig_q;
		ndig_d   = ndig_q;
		pad_d    = pad_q;
		strobe_d = 1'b0;
		res_d    = res_q;
		dab_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					upper_d = cmd.req_type[1];
					zpad_d  = cmd.zero_pad;
					neg_d   = in_neg;
					wsat_d  = (cmd.field_width > MaxW) ? MaxW : cmd.field_width;
					if (is_dec) begin
						dab_load = 1'b1;
						state_d  = ST_CONV;
					end else begin
						dig_d   = {cmd.value, {(BcdW-MagW){1'b0}}};
						ndig_d  = 4'(HexDigits);
						state_d = ST_TRIM;
					end
				end
			end
			ST_CONV: begin
				if (dab_done) begin
					dig_d   = dab_bcd;
					ndig_d  = 4'(DecDigits);
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				// Drop leading zero digits, but always keep at least one.
				if (top_dig == 4'd0 && ndig_q > 4'd1) begin
					dig_d  = {dig_q[BcdW-5:0], 4'b0000};
					ndig_d = ndig_q - 4'd1;
				end else begin
					pad_d = pad_calc;
					if (neg_q && zpad_q) begin
						state_d = ST_SIGN;
					end else if (pad_calc != 4'd0) begin
						state_d = ST_PAD;
					end else if (neg_q) begin
						state_d = ST_SIGN;
					end else begin
						state_d = ST_DIGIT;
					end
				end
			end
			ST_PAD: begin
				strobe_d        = 1'b1;
				res_d.out_char  = pad_char;
				res_d.last_char = 1'b0;
				pad_d           = pad_q - 4'd1;
				if (pad_q == 4'd1) begin
					state_d = (neg_q && !zpad_q) ? ST_SIGN : ST_DIGIT;
				end
			end
			ST_SIGN: begin
				// With zero padding the sign leads and the zeros follow it.
				strobe_d        = 1'b1;
				res_d.out_char  = CHR_MINUS;
				res_d.last_char = 1'b0;
				state_d         = (zpad_q && pad_q != 4'd0) ? ST_PAD : ST_DIGIT;
			end
			ST_DIGIT: begin
				strobe_d        = 1'b1;
				res_d.out_char  = dig_char;
				res_d.last_char = (ndig_q == 4'd1);
				dig_d           = {dig_q[BcdW-5:0], 4'b0000};
				ndig_d          = ndig_q - 4'd1;
				if (ndig_q == 4'd1) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		upper_q <= upper_d;
		zpad_q  <= zpad_d;
		neg_q   <= neg_d;
		wsat_q  <= wsat_d;
		dig_q   <= dig_d;
		ndig_q  <= ndig_d;
		pad_q   <= pad_d;
		res_q   <= res_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = res_q;

endmodule
